// ===== design/clcp_pkg.sv =====
// Package with the constants, codes and types of the copy/literal command parser.
package clcp_pkg;

  localparam int unsigned PageBytes = 2048;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DestW     = 11;
  localparam int unsigned SrcW      = 23;
  localparam int unsigned LenW      = 14;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CntW      = 3;
  localparam int unsigned CmdDepth  = 5;
  localparam int unsigned ShortLenW = 6;
  localparam int unsigned WposW     = $clog2(PageBytes + 1);
  localparam int unsigned SumW      = ((WposW > LenW) ? WposW : LenW) + 1;

  localparam int unsigned CopyBit   = 7;
  localparam int unsigned LongBit   = 6;
  localparam int unsigned SelRamBit = 7;

  typedef enum logic [2:0] {
    PhCmd    = 3'b001,
    PhParams = 3'b010,
    PhRaw    = 3'b100
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KindRaw   = 2'd0,
    KindFlash = 2'd1,
    KindRam   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DestW-1:0]  dest_index;
    logic [ByteW-1:0]  byte_value;
    logic [SrcW-1:0]   src_offset;
    logic [LenW-1:0]   copy_length;
    logic              overflow;
  } result_t;

endpackage

// ===== design/clcp_in_if.sv =====
// Input channel interface: one stream byte or a page flush per transaction.
interface clcp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink (input valid, input op, input in_byte, output ready);
endinterface

// ===== design/clcp_out_if.sv =====
// Output channel interface: one raw byte write or one copy descriptor per transaction.
interface clcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] dest_index;
  logic [7:0]  byte_value;
  logic [22:0] src_offset;
  logic [13:0] copy_length;
  logic        overflow;

  modport source (
    output valid, output kind, output dest_index, output byte_value,
    output src_offset, output copy_length, output overflow, input ready
  );
  modport sink (
    input valid, input kind, input dest_index, input byte_value,
    input src_offset, input copy_length, input overflow, output ready
  );
endinterface

// ===== design/copy_literal_command_parser_unit.sv =====
// Path: a transaction accepted into the input register is parsed when it advances, which loads its
// result, if it has one, into the output register, from which the sink takes it.
// Throughput: one input transaction per cycle, set by the single parse step between the
// input register and the output register; a full output register stalls only bytes with a result.
// Reset: asynchronous, active low; parsing restarts at a command byte, write position zero.
module copy_literal_command_parser_unit import clcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clcp_in_if.sink    in_i,
  clcp_out_if.source out_o
);

  logic             in_valid_q;
  logic             in_op_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;

  logic             res_valid;
  result_t          res;
  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_i.ready = !in_valid_q || advance;

  clcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .op_i        (in_op_q),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q   <= in_i.op;
      in_byte_q <= in_i.in_byte;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.dest_index  = out_q.dest_index;
  assign out_o.byte_value  = out_q.byte_value;
  assign out_o.src_offset  = out_q.src_offset;
  assign out_o.copy_length = out_q.copy_length;
  assign out_o.overflow    = out_q.overflow;

endmodule

// ===== design/clcp_parser.sv =====
// Parse state and next-state logic: command decode, parameter gathering and write position.
module clcp_parser import clcp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             op_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e                 phase_q, phase_d;
  logic [ByteW-1:0]       cb_q [CmdDepth];
  logic [ByteW-1:0]       cb_n [CmdDepth];
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        expected_q, expected_d;
  logic [LenW-1:0]        raw_count_q, raw_count_d;
  logic [WposW-1:0]       wpos_q, wpos_d;

  logic [CntW-1:0]        cnt_inc;
  logic [LenW-1:0]        raw_inc;
  logic                   is_long;
  logic [LenW-1:0]        cmd_len;
  logic [ByteW-1:0]       src_b0, src_b1, src_b2;
  logic [SumW-1:0]        wpos_sum;

  assign cnt_inc  = count_q + CntW'(1);
  assign raw_inc  = raw_count_q + LenW'(1);
  assign is_long  = cb_n[0][LongBit];
  assign cmd_len  = is_long ? {cb_n[0][ShortLenW-1:0], cb_n[1]}
                            : LenW'(cb_n[0][ShortLenW-1:0]);
  assign src_b0   = is_long ? cb_n[2] : cb_n[1];
  assign src_b1   = is_long ? cb_n[3] : cb_n[2];
  assign src_b2   = is_long ? cb_n[4] : cb_n[3];
  assign wpos_sum = SumW'(wpos_q) + SumW'(cmd_len);

  always_comb begin
    cb_n        = cb_q;
    phase_d     = phase_q;
    count_d     = count_q;
    expected_d  = expected_q;
    raw_count_d = raw_count_q;
    wpos_d      = wpos_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.dest_index = wpos_q[DestW-1:0];
    if (op_i) begin
      wpos_d = '0;
    end else begin
      case (phase_q)
        PhParams: begin
          for (int i = 0; i < CmdDepth; i++) begin
            if (count_q == CntW'(i)) begin
              cb_n[i] = byte_i;
            end
          end
          count_d = cnt_inc;
          if (cnt_inc >= expected_q) begin
            if (cb_n[0][CopyBit]) begin
              res_valid_o       = 1'b1;
              res_o.kind        = src_b0[SelRamBit] ? KindRam : KindFlash;
              res_o.src_offset  = {src_b0[SelRamBit-1:0], src_b1, src_b2};
              res_o.copy_length = cmd_len;
              phase_d           = PhCmd;
              if (wpos_sum > SumW'(PageBytes)) begin
                res_o.overflow = 1'b1;
                wpos_d         = WposW'(PageBytes);
              end else begin
                wpos_d = wpos_sum[WposW-1:0];
              end
            end else begin
              phase_d     = PhRaw;
              raw_count_d = '0;
            end
          end
        end
        PhRaw: begin
          res_valid_o      = 1'b1;
          res_o.kind       = KindRaw;
          res_o.byte_value = byte_i;
          if (wpos_q >= WposW'(PageBytes)) begin
            res_o.overflow = 1'b1;
          end else begin
            wpos_d = wpos_q + WposW'(1);
          end
          raw_count_d = raw_inc;
          if (raw_inc >= cmd_len) begin
            phase_d = PhCmd;
          end
        end
        default: begin
          cb_n[0]    = byte_i;
          count_d    = CntW'(1);
          expected_d = CntW'(1) + (byte_i[CopyBit] ? CntW'(3) : CntW'(0))
                                + (byte_i[LongBit] ? CntW'(1) : CntW'(0));
          if (expected_d > CntW'(1)) begin
            phase_d = PhParams;
          end else begin
            phase_d     = PhRaw;
            raw_count_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCmd;
      count_q     <= '0;
      expected_q  <= '0;
      raw_count_q <= '0;
      wpos_q      <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      expected_q  <= expected_d;
      raw_count_q <= raw_count_d;
      wpos_q      <= wpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      cb_q <= cb_n;
    end
  end

endmodule

// ===== design/clcp_checker.sv =====
// Port-level checker for the parser output and its bind to the top level.
module clcp_checker import clcp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [KindW-1:0] kind_i,
  input logic [DestW-1:0] dest_index_i,
  input logic [ByteW-1:0] byte_value_i,
  input logic [SrcW-1:0]  src_offset_i,
  input logic [LenW-1:0]  copy_length_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(dest_index_i)
      && $stable(src_offset_i) && $stable(copy_length_i) && $stable(byte_value_i))
    else $error("Output transaction changed while stalled.");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i == KindRaw || kind_i == KindFlash || kind_i == KindRam)
    else $error("Output kind carries an unused code.");

  a_raw_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindRaw |-> src_offset_i == '0 && copy_length_i == '0)
    else $error("Raw byte write carries copy fields.");

  a_copy_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KindRaw |-> byte_value_i == '0)
    else $error("Copy descriptor carries a literal byte.");

endmodule

bind copy_literal_command_parser_unit clcp_checker u_clcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .dest_index_i  (out_o.dest_index),
  .byte_value_i  (out_o.byte_value),
  .src_offset_i  (out_o.src_offset),
  .copy_length_i (out_o.copy_length)
);
